/* design/csaf_pkg.sv */
// Shared types and constants of the cross stencil average filter.
// Used by the line store and the top level; no dependencies.
package csaf_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = 3 * CHAN_W;

  // Configuration field widths and their largest raw values
  localparam int unsigned RADIUS_W      = 4;
  localparam int unsigned FWIDTH_W      = 11;
  localparam int unsigned FHEIGHT_W     = 13;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned RADIUS_RAW_HI = (1 << RADIUS_W) - 1;
  localparam int unsigned FWIDTH_RAW_HI = (1 << FWIDTH_W) - 1;
  localparam int unsigned FHEIGHT_RAW_HI = (1 << FHEIGHT_W) - 1;

  // Used ranges and reset values of the registers
  localparam int unsigned MIN_RADIUS    = 1;
  localparam int unsigned MIN_FWIDTH    = 4;
  localparam int unsigned MIN_FHEIGHT   = 4;
  localparam int unsigned RESET_RADIUS  = 3;
  localparam int unsigned RESET_FWIDTH  = 640;
  localparam int unsigned RESET_FHEIGHT = 480;

  // radius * width + radius + 1 always fits here
  localparam int unsigned LAG_W = RADIUS_W + FWIDTH_W;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_RADIUS = 8;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_FWIDTH  = 2'd1,
    CFG_FHEIGHT = 2'd2
  } cfg_index_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0_in;
    logic [CHAN_W-1:0] chan1_in;
    logic [CHAN_W-1:0] chan2_in;
    logic              drain;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0_out;
    logic [CHAN_W-1:0] chan1_out;
    logic [CHAN_W-1:0] chan2_out;
    logic              last_of_frame;
  } out_item_t;

endpackage

/* design/csaf_line_store.sv */
// Line store of the cross stencil average filter: one write port, two read
// ports with registered read data. Depends on csaf_pkg.
module csaf_line_store
  import csaf_pkg::*;
#(
  parameter int unsigned ADDR_W = 15,
  parameter int unsigned DEPTH  = 17408
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  pix_t              wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output pix_t              rdata_a_o,
  output pix_t              rdata_b_o
);

  pix_t mem_q [DEPTH];
  pix_t rd_a_q;
  pix_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

/* design/cross_stencil_average_filter_core.sv */
// Cross stencil average filter: takes one pixel item per clock when not
// stalled and gives at most one result per item; the result an item releases
// passes the line store read register, then the output register, where it is
// averaged. While the output does not stall, the sustained rate of one item
// per clock is set by the line store, which takes the pixel write and both
// neighbour reads of an item in the same cycle; the left and lower neighbours
// come from short shift lines beside it. The store holds 2*MAX_RADIUS+1 rows
// and needs no clearing pass after reset. Results trail the pixels by radius
// rows plus radius pixels; send drain items after the last pixel of a frame
// to flush its tail. Depends on csaf_pkg and csaf_line_store.
module cross_stencil_average_filter_core
  import csaf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned STORE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int unsigned CW         = $clog2(MAX_WIDTH);
  localparam int unsigned RW         = $clog2(MAX_HEIGHT);
  localparam int unsigned SW         = $clog2(STORE_ROWS);
  localparam int unsigned AW         = SW + CW;
  localparam int unsigned DEPTH      = STORE_ROWS << CW;
  localparam int unsigned WIN_DEPTH  = 2 * MAX_RADIUS;
  localparam int unsigned WIW        = $clog2(WIN_DEPTH);
  localparam int unsigned DLW        = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
  localparam int unsigned XW         = ((CW > FWIDTH_W) ? CW : FWIDTH_W) + 1;
  localparam int unsigned YW         = ((RW > FHEIGHT_W) ? RW : FHEIGHT_W) + 1;
  localparam int unsigned UW         = ((SW > RADIUS_W) ? SW : RADIUS_W) + 1;
  localparam int unsigned R_HI = (MAX_RADIUS < RADIUS_RAW_HI) ? MAX_RADIUS : RADIUS_RAW_HI;
  localparam int unsigned W_HI = (MAX_WIDTH < FWIDTH_RAW_HI) ? MAX_WIDTH : FWIDTH_RAW_HI;
  localparam int unsigned H_HI = (MAX_HEIGHT < FHEIGHT_RAW_HI) ? MAX_HEIGHT : FHEIGHT_RAW_HI;
  localparam int unsigned R_RST = (RESET_RADIUS > R_HI) ? R_HI : RESET_RADIUS;
  localparam int unsigned W_RST = (RESET_FWIDTH > W_HI) ? W_HI : RESET_FWIDTH;
  localparam int unsigned H_RST = (RESET_FHEIGHT > H_HI) ? H_HI : RESET_FHEIGHT;

  function automatic logic [CHAN_W-1:0] mean4(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c,
                                              input logic [CHAN_W-1:0] d);
    logic [CHAN_W+1:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return sum[CHAN_W+1:2];
  endfunction

  // Configuration, kept already clamped into the used ranges
  logic [RADIUS_W-1:0]  radius_q, radius_d;
  logic [FWIDTH_W-1:0]  width_q, width_d;
  logic [FHEIGHT_W-1:0] height_q, height_d;
  logic                 cfg_hit;

  // Frame positions
  logic [CW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]    in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SW-1:0]    in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic             in_done_q, in_done_d;
  logic [LAG_W-1:0] gap_q, gap_d;

  // Item handling
  logic             acc, wr, emit, emit_last;
  logic             in_last_col, in_last_row, out_last_col, out_last_row;
  logic             done_after, interior;
  logic [LAG_W-1:0] lag, gap_after;
  pix_t             pix_in;

  // Store addressing
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [XW-1:0] rt_col;
  logic [SW-1:0] up_slot, next_slot;

  // Read stage and output stage
  logic      s1_valid_q, s1_valid_d, s1_adv;
  logic      s1_interior_q, s1_last_q;
  pix_t      s1_dn_q;
  pix_t      rd_a, rd_b, lf;
  pix_t      dline_q [MAX_RADIUS];
  pix_t      win_q [WIN_DEPTH];
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // ---------------------------------------------------------------------
  // Configuration
  always_comb begin
    radius_d = radius_q;
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_RADIUS: begin
          cfg_hit = 1'b1;
          if (cfg_wdata_i[RADIUS_W-1:0] < RADIUS_W'(MIN_RADIUS)) begin
            radius_d = RADIUS_W'(MIN_RADIUS);
          end else if (cfg_wdata_i[RADIUS_W-1:0] > RADIUS_W'(R_HI)) begin
            radius_d = RADIUS_W'(R_HI);
          end else begin
            radius_d = cfg_wdata_i[RADIUS_W-1:0];
          end
        end
        CFG_FWIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_wdata_i[FWIDTH_W-1:0] < FWIDTH_W'(MIN_FWIDTH)) begin
            width_d = FWIDTH_W'(MIN_FWIDTH);
          end else if (cfg_wdata_i[FWIDTH_W-1:0] > FWIDTH_W'(W_HI)) begin
            width_d = FWIDTH_W'(W_HI);
          end else begin
            width_d = cfg_wdata_i[FWIDTH_W-1:0];
          end
        end
        CFG_FHEIGHT: begin
          cfg_hit = 1'b1;
          if (cfg_wdata_i[FHEIGHT_W-1:0] < FHEIGHT_W'(MIN_FHEIGHT)) begin
            height_d = FHEIGHT_W'(MIN_FHEIGHT);
          end else if (cfg_wdata_i[FHEIGHT_W-1:0] > FHEIGHT_W'(H_HI)) begin
            height_d = FHEIGHT_W'(H_HI);
          end else begin
            height_d = cfg_wdata_i[FHEIGHT_W-1:0];
          end
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Item acceptance and release
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign acc        = in_valid_i && !in_stall_o;

  assign pix_in = {in_item_i.chan2_in, in_item_i.chan1_in, in_item_i.chan0_in};

  assign in_last_col  = XW'(in_col_q) == XW'(width_q) - XW'(1);
  assign in_last_row  = YW'(in_row_q) == YW'(height_q) - YW'(1);
  assign out_last_col = XW'(out_col_q) == XW'(width_q) - XW'(1);
  assign out_last_row = YW'(out_row_q) == YW'(height_q) - YW'(1);

  // Pixels after the frame is complete are dropped
  assign wr         = acc && !in_item_i.drain && !in_done_q;
  assign done_after = in_done_q || (wr && in_last_col && in_last_row);
  assign lag        = LAG_W'(radius_q) * LAG_W'(width_q) + LAG_W'(radius_q);
  assign gap_after  = gap_q + LAG_W'(wr);
  assign emit       = acc && (done_after || gap_after > lag);
  assign emit_last  = emit && out_last_col && out_last_row;

  assign interior = (YW'(out_row_q) >= YW'(radius_q) + YW'(1)) &&
                    (YW'(out_row_q) + YW'(radius_q) + YW'(1) < YW'(height_q)) &&
                    (XW'(out_col_q) >= XW'(radius_q) + XW'(1)) &&
                    (XW'(out_col_q) + XW'(radius_q) + XW'(1) < XW'(width_q));

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    in_done_d  = in_done_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    gap_d      = gap_q;
    if (cfg_hit || emit_last) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      in_done_d  = 1'b0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      gap_d      = '0;
    end else begin
      in_done_d = done_after;
      gap_d     = gap_after - LAG_W'(emit);
      if (wr) begin
        if (in_last_col) begin
          in_col_d  = '0;
          in_row_d  = RW'(in_row_q + RW'(1));
          in_slot_d = (in_slot_q == SW'(STORE_ROWS - 1)) ? '0 : SW'(in_slot_q + SW'(1));
        end else begin
          in_col_d = CW'(in_col_q + CW'(1));
        end
      end
      if (emit) begin
        if (out_last_col) begin
          out_col_d  = '0;
          out_row_d  = RW'(out_row_q + RW'(1));
          out_slot_d = next_slot;
        end else begin
          out_col_d = CW'(out_col_q + CW'(1));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Store addresses: port A reads radius pixels ahead of the output
  // position (it feeds the row window), port B the upper neighbour for
  // interior pixels and the pixel itself otherwise.
  assign next_slot = (out_slot_q == SW'(STORE_ROWS - 1)) ? '0 : SW'(out_slot_q + SW'(1));
  assign rt_col    = XW'(out_col_q) + XW'(radius_q);
  assign up_slot   = (UW'(out_slot_q) >= UW'(radius_q)) ?
                     SW'(UW'(out_slot_q) - UW'(radius_q)) :
                     SW'(UW'(out_slot_q) + UW'(STORE_ROWS) - UW'(radius_q));

  always_comb begin
    waddr = {in_slot_q, in_col_q};
    // Wrap onto the next row when the look-ahead crosses the row end
    if (rt_col >= XW'(width_q)) begin
      raddr_a = {next_slot, CW'(rt_col - XW'(width_q))};
    end else begin
      raddr_a = {out_slot_q, CW'(rt_col)};
    end
    raddr_b = interior ? {up_slot, out_col_q} : {out_slot_q, out_col_q};
  end

  csaf_line_store #(
    .ADDR_W (AW),
    .DEPTH  (DEPTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (wr),
    .waddr_i   (waddr),
    .wdata_i   (pix_in),
    .re_i      (emit),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ---------------------------------------------------------------------
  // Lower neighbour: the pixel written radius writes back
  always_ff @(posedge clk_i) begin
    if (wr) begin
      dline_q[0] <= pix_in;
      for (int i = 1; i < MAX_RADIUS; i++) begin
        dline_q[i] <= dline_q[i-1];
      end
    end
  end

  // Left neighbour: the look-ahead read of 2*radius results back
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q[0] <= rd_a;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  assign lf = win_q[WIW'({radius_q, 1'b0} - (RADIUS_W + 1)'(1))];

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_interior_q <= interior;
      s1_last_q     <= out_last_col && out_last_row;
      s1_dn_q       <= dline_q[DLW'(radius_q - RADIUS_W'(1))];
    end
  end

  // ---------------------------------------------------------------------
  // Averaging into the output register
  always_comb begin
    s1_valid_d  = emit || (s1_valid_q && !s1_adv);
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    out_item_d.last_of_frame = s1_last_q;
    if (s1_interior_q) begin
      out_item_d.chan0_out = mean4(rd_b[7:0], s1_dn_q[7:0], lf[7:0], rd_a[7:0]);
      out_item_d.chan1_out = mean4(rd_b[15:8], s1_dn_q[15:8], lf[15:8], rd_a[15:8]);
      out_item_d.chan2_out = mean4(rd_b[23:16], s1_dn_q[23:16], lf[23:16], rd_a[23:16]);
    end else begin
      out_item_d.chan0_out = rd_b[7:0];
      out_item_d.chan1_out = rd_b[15:8];
      out_item_d.chan2_out = rd_b[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RADIUS_W'(R_RST);
      width_q     <= FWIDTH_W'(W_RST);
      height_q    <= FHEIGHT_W'(H_RST);
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      in_done_q   <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      gap_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      radius_q    <= radius_d;
      width_q     <= width_d;
      height_q    <= height_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      in_slot_q   <= in_slot_d;
      in_done_q   <= in_done_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_slot_q  <= out_slot_d;
      gap_q       <= gap_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------
  // Assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni) gap_q <= lag)
    else $error("output position fell more than the lag behind the input");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (emit && interior) |-> wr)
    else $error("interior result released without the matching pixel write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (s1_valid_q && !s1_adv) |-> !emit)
    else $error("read stage overwritten while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   emit_last |=> (gap_q == '0 && !in_done_q && in_col_q == '0 &&
                                  in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
    else $error("positions not cleared after the last item of a frame");

endmodule

/* sim/tb_top.sv */
// Testbench for cross_stencil_average_filter_core: streams pixel frames under several
// register settings, predicts every filtered pixel and compares it with the output.
// Depends on csaf_pkg and the RTL of the filter core.
`timescale 1ns / 100ps

module tb_top;
  import csaf_pkg::*;

  localparam int unsigned STORE_ROWS    = 2 * DEF_MAX_RADIUS + 1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PIXELS = 100;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_item_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_item_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  cross_stencil_average_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Filter state as the block should hold it
  pix_t                 px_store [STORE_ROWS * DEF_MAX_WIDTH];
  int unsigned          pix_in_count = 0;
  int unsigned          res_out_count = 0;
  logic [RADIUS_W-1:0]  reg_radius = RADIUS_W'(RESET_RADIUS);
  logic [FWIDTH_W-1:0]  reg_width  = FWIDTH_W'(RESET_FWIDTH);
  logic [FHEIGHT_W-1:0] reg_height = FHEIGHT_W'(RESET_FHEIGHT);

  out_item_t blurred_q [$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        bursty = 1'b1;
  int        stall_mode = 0;
  int        stall_timer = 0;
  int        stall_phase = 0;

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_radius();
    return clamp_u(reg_radius, MIN_RADIUS, DEF_MAX_RADIUS);
  endfunction

  function automatic int unsigned eff_width();
    return clamp_u(reg_width, MIN_FWIDTH, DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned frame_size();
    return eff_width() * clamp_u(reg_height, MIN_FHEIGHT, DEF_MAX_HEIGHT);
  endfunction

  function automatic int unsigned slot(int unsigned row, int unsigned col);
    return (row % STORE_ROWS) * DEF_MAX_WIDTH + col;
  endfunction

  function automatic logic [CHAN_W-1:0] mean4(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                              logic [CHAN_W-1:0] c, logic [CHAN_W-1:0] d);
    logic [CHAN_W+1:0] sum;
    sum = a + b + c + d;
    return sum[CHAN_W+1:2];
  endfunction

  // Any write to a real register restarts the frame
  function automatic void load_register(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_RADIUS:  reg_radius = data[RADIUS_W-1:0];
      CFG_FWIDTH:  reg_width  = data[FWIDTH_W-1:0];
      CFG_FHEIGHT: reg_height = data[FHEIGHT_W-1:0];
      default: return;
    endcase
    pix_in_count  = 0;
    res_out_count = 0;
  endfunction

  function automatic bit blur_step(input in_item_t item, output out_item_t res);
    int unsigned r, w, h, size, need, row, col;
    pix_t up, dn, lf, rt, centre;
    r    = eff_radius();
    w    = eff_width();
    h    = clamp_u(reg_height, MIN_FHEIGHT, DEF_MAX_HEIGHT);
    size = w * h;
    res  = '0;
    if (!item.drain && pix_in_count < size) begin
      px_store[slot(pix_in_count / w, pix_in_count % w)] =
        {item.chan2_in, item.chan1_in, item.chan0_in};
      pix_in_count++;
    end
    if (res_out_count >= size) return 1'b0;
    need = res_out_count + r * w + r + 1;
    if (need > size) need = size;
    if (pix_in_count < need) return 1'b0;
    row    = res_out_count / w;
    col    = res_out_count % w;
    centre = px_store[slot(row, col)];
    if (row >= r + 1 && row + r + 1 < h && col >= r + 1 && col + r + 1 < w) begin
      up = px_store[slot(row - r, col)];
      dn = px_store[slot(row + r, col)];
      lf = px_store[slot(row, col - r)];
      rt = px_store[slot(row, col + r)];
      res.chan0_out = mean4(up[7:0], dn[7:0], lf[7:0], rt[7:0]);
      res.chan1_out = mean4(up[15:8], dn[15:8], lf[15:8], rt[15:8]);
      res.chan2_out = mean4(up[23:16], dn[23:16], lf[23:16], rt[23:16]);
    end else begin
      {res.chan2_out, res.chan1_out, res.chan0_out} = centre;
    end
    res_out_count++;
    if (res_out_count == size) begin
      res.last_of_frame = 1'b1;
      pix_in_count  = 0;
      res_out_count = 0;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns %s: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    out_item_t want, res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (blurred_q.size() == 0) begin
          $display("%0t ns unexpected result: expected none, got %h", $time, out_item_o);
          mismatches++;
        end else begin
          want = blurred_q.pop_front();
          check_field("chan0_out", want.chan0_out, out_item_o.chan0_out);
          check_field("chan1_out", want.chan1_out, out_item_o.chan1_out);
          check_field("chan2_out", want.chan2_out, out_item_o.chan2_out);
          check_field("last_of_frame", want.last_of_frame, out_item_o.last_of_frame);
        end
      end
      if (cfg_we_i) load_register(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o && blur_step(in_item_i, res)) blurred_q.push_back(res);
    end
  end

  // Output backpressure: switch between none, light, periodic and heavy stalls
  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ((stall_phase % 7) < 3);
      3:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= 1'b0;
    endcase
  end

  function automatic logic [CHAN_W-1:0] chan_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t pixel_item(bit drain);
    in_item_t item;
    item.chan0_in = chan_value();
    item.chan1_in = chan_value();
    item.chan2_in = chan_value();
    item.drain    = drain;
    return item;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = bursty ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (blurred_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_frame(int unsigned radius, int unsigned width, int unsigned height);
    wait_idle();
    write_cfg(CFG_RADIUS, CFG_DATA_W'(radius));
    write_cfg(CFG_FWIDTH, CFG_DATA_W'(width));
    write_cfg(CFG_FHEIGHT, CFG_DATA_W'(height));
  endtask

  // Send n pixels with drains mixed in; once the frame is complete, flush its tail
  task automatic send_frame(int unsigned n, int unsigned drain_pct, int unsigned tail_pixel_pct);
    for (int unsigned i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < drain_pct) send_item(pixel_item(1'b1));
      send_item(pixel_item(1'b0));
    end
    while (pix_in_count != 0 && pix_in_count == frame_size())
      send_item(pixel_item($urandom_range(0, 99) >= tail_pixel_pct));
  endtask

  function automatic logic [CFG_DATA_W-1:0] cfg_word(int unsigned val, int unsigned field_w);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(val);
    if (field_w < CFG_DATA_W && $urandom_range(0, 3) == 0)
      word |= CFG_DATA_W'($urandom_range(0, (1 << (CFG_DATA_W - field_w)) - 1) << field_w);
    return word;
  endfunction

  // Partial frame at the reset settings
  task automatic test_reset_defaults();
    send_frame(24, 2, 0);
  endtask

  task automatic test_smallest_frame();
    set_frame(0, 0, 0);
    send_frame(16, 0, 50);
  endtask

  task automatic test_channel_extremes();
    set_frame(1, 7, 7);
    send_frame(49, 0, 0);
  endtask

  task automatic test_oversized_radius();
    set_frame(RADIUS_RAW_HI, 5, 4);
    send_frame(20, 5, 30);
  endtask

  // Stop right after the centre pixel, the only interior one, comes out
  task automatic test_largest_radius();
    set_frame(DEF_MAX_RADIUS, 19, 19);
    send_frame(341, 0, 0);
  endtask

  // Partial frame: only the first results of the widest rows come out
  task automatic test_widest_frame();
    set_frame(1, FWIDTH_RAW_HI, 5);
    send_frame(DEF_MAX_WIDTH + 8, 0, 10);
  endtask

  // Start a very tall frame, then abort it by shrinking the height
  task automatic test_tall_frame_abort();
    set_frame(2, 9, FHEIGHT_RAW_HI);
    send_frame(30, 0, 0);
    wait_idle();
    write_cfg(CFG_FHEIGHT, CFG_DATA_W'(7));
    send_frame(63, 0, 0);
  endtask

  // A write to the unused index must leave the frame running
  task automatic test_spare_register();
    set_frame(1, 6, 6);
    send_frame(20, 0, 0);
    wait_idle();
    write_cfg(CFG_SPARE, '1);
    send_frame(16, 0, 0);
  endtask

  task automatic test_drain_and_overrun();
    set_frame(1, 6, 6);
    send_item(pixel_item(1'b1));
    send_frame(36, 40, 100);
    send_frame(36, 0, 0);
  endtask

  task automatic test_random_frames();
    int unsigned done_pixels, n, val;
    bit aborted, wrote;
    done_pixels = 0;
    aborted     = 1'b0;
    while (done_pixels < RANDOM_PIXELS) begin
      bursty = ($urandom_range(0, 3) != 0);
      if (aborted || $urandom_range(0, 5) != 0) begin
        wait_idle();
        wrote = 1'b0;
        if ($urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 9))
            0:       val = $urandom_range(0, RADIUS_RAW_HI);
            1, 2:    val = $urandom_range(5, DEF_MAX_RADIUS);
            default: val = $urandom_range(1, 4);
          endcase
          write_cfg(CFG_RADIUS, cfg_word(val, RADIUS_W));
          wrote = 1'b1;
        end
        if ($urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 9))
            0:       val = $urandom_range(0, 3);
            1:       val = $urandom_range(21, 40);
            default: val = $urandom_range(4, 16);
          endcase
          write_cfg(CFG_FWIDTH, cfg_word(val, FWIDTH_W));
          wrote = 1'b1;
        end
        if (!wrote || $urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 9))
            0:       val = $urandom_range(0, 3);
            1:       val = $urandom_range(13, 24);
            default: val = $urandom_range(4, 12);
          endcase
          write_cfg(CFG_FHEIGHT, cfg_word(val, FHEIGHT_W));
        end
      end
      n = frame_size();
      aborted = ($urandom_range(0, 6) == 0);
      if (aborted) n = $urandom_range(0, n - 1);
      send_frame(n, $urandom_range(0, 10), $urandom_range(0, 50));
      done_pixels += n;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_smallest_frame();
    test_channel_extremes();
    test_oversized_radius();
    test_largest_radius();
    test_widest_frame();
    test_tall_frame_abort();
    test_spare_register();
    test_drain_and_overrun();
    test_random_frames();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && blurred_q.size() == 0) begin
      $display("cross_stencil_average_filter_core: match");
    end else begin
      $display("cross_stencil_average_filter_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("cross_stencil_average_filter_core: mismatch");
    $finish;
  end

endmodule
